// ===== design/osng_pkg.sv =====
package osng_pkg;

  localparam int OCT_N = 4;
  localparam int OCT_W = $clog2(OCT_N);
  localparam int V_W = 20;
  localparam int MIX_W = 28;
  localparam int WSUM_W = 10;

  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_16 = 2'd1;
  localparam logic [1:0] SH_32 = 2'd2;

  typedef struct packed {
    logic              add;
    logic [1:0]        sh;
    logic signed [39:0] a;
    logic signed [17:0] b;
  } mac_op_t;

  localparam logic [7:0] PERM [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13, 8'd201, 8'd95, 8'd96, 8'd53,
    8'd194, 8'd233, 8'd7, 8'd225, 8'd140, 8'd36, 8'd103, 8'd30, 8'd69, 8'd142, 8'd8, 8'd99,
    8'd37, 8'd240, 8'd21, 8'd10, 8'd23, 8'd190, 8'd6, 8'd148, 8'd247, 8'd120, 8'd234, 8'd75,
    8'd0, 8'd26, 8'd197, 8'd62, 8'd94, 8'd252, 8'd219, 8'd203, 8'd117, 8'd35, 8'd11, 8'd32,
    8'd57, 8'd177, 8'd33, 8'd88, 8'd237, 8'd149, 8'd56, 8'd87, 8'd174, 8'd20, 8'd125, 8'd136,
    8'd171, 8'd168, 8'd68, 8'd175, 8'd74, 8'd165, 8'd71, 8'd134, 8'd139, 8'd48, 8'd27, 8'd166,
    8'd77, 8'd146, 8'd158, 8'd231, 8'd83, 8'd111, 8'd229, 8'd122, 8'd60, 8'd211, 8'd133, 8'd230,
    8'd220, 8'd105, 8'd92, 8'd41, 8'd55, 8'd46, 8'd245, 8'd40, 8'd244, 8'd102, 8'd143, 8'd54,
    8'd65, 8'd25, 8'd63, 8'd161, 8'd1, 8'd216, 8'd80, 8'd73, 8'd209, 8'd76, 8'd132, 8'd187,
    8'd208, 8'd89, 8'd18, 8'd169, 8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64, 8'd52, 8'd217, 8'd226, 8'd250,
    8'd124, 8'd123, 8'd5, 8'd202, 8'd38, 8'd147, 8'd118, 8'd126, 8'd255, 8'd82, 8'd85, 8'd212,
    8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16, 8'd58, 8'd17, 8'd182, 8'd189, 8'd28, 8'd42,
    8'd223, 8'd183, 8'd170, 8'd213, 8'd119, 8'd248, 8'd152, 8'd2, 8'd44, 8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43, 8'd172, 8'd9, 8'd129, 8'd22, 8'd39, 8'd253,
    8'd19, 8'd98, 8'd108, 8'd110, 8'd79, 8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97, 8'd228, 8'd251, 8'd34, 8'd242, 8'd193, 8'd238, 8'd210, 8'd144, 8'd12,
    8'd191, 8'd179, 8'd162, 8'd241, 8'd81, 8'd51, 8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107,
    8'd49, 8'd192, 8'd214, 8'd31, 8'd181, 8'd199, 8'd106, 8'd157, 8'd184, 8'd84, 8'd204, 8'd176,
    8'd115, 8'd121, 8'd50, 8'd45, 8'd127, 8'd4, 8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67, 8'd29, 8'd24, 8'd72, 8'd243, 8'd141, 8'd128, 8'd195, 8'd78, 8'd66,
    8'd215, 8'd61, 8'd156, 8'd180
  };

  function automatic logic [15:0] sat16(input logic signed [MIX_W-1:0] x);
    logic [15:0] r;
    if (x > $signed(MIX_W'(32767))) begin
      r = 16'h7fff;
    end else if (x < -$signed(MIX_W'(32768))) begin
      r = 16'h8000;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

endpackage

// ===== design/osng_mac.sv =====
module osng_mac
  import osng_pkg::*;
(
  input  logic        clk,
  input  mac_op_t     op,
  output logic [63:0] acc
);

  logic signed [57:0] prod;
  logic [63:0] wide;
  logic [63:0] term;

  assign prod = op.a * op.b;
  assign wide = {{6{prod[57]}}, prod};

  always_comb begin
    unique case (op.sh)
      SH_16:   term = wide << 16;
      SH_32:   term = wide << 32;
      default: term = wide;
    endcase
  end

  always_ff @(posedge clk) begin
    if (op.add) begin
      acc <= acc + term;
    end else begin
      acc <= term;
    end
  end

endmodule

// ===== design/osng_div.sv =====
module osng_div
  import osng_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MIX_W-1:0]  dividend,
  input  logic [WSUM_W-1:0] divisor,
  output logic              busy,
  output logic [MIX_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(MIX_W + 1);

  logic [WSUM_W-1:0] dsr;
  logic [WSUM_W-1:0] rem;
  logic [CNT_W-1:0]  cnt;
  logic [WSUM_W:0]   trial;
  logic              fits;

  assign trial = {rem, quotient[MIX_W-1]};
  assign fits = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CNT_W'(MIX_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      quotient <= {quotient[MIX_W-2:0], fits};
      if (fits) begin
        rem <= WSUM_W'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[WSUM_W-1:0];
      end
    end
  end

endmodule

// ===== design/osng_seq.sv =====
module osng_seq
  import osng_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [15:0]       speed_cv,
  input  logic              speed_cv_present,
  input  logic [15:0]       amp_cv,
  input  logic              amp_cv_present,
  input  logic [47:0]       elapsed_time,
  input  logic [15:0]       base_speed,
  input  logic [8:0]        speed_blend,
  input  logic [11:0]       base_amplitude,
  input  logic [8:0]        amplitude_blend,
  input  logic [31:0]       octave_weights,
  output mac_op_t           op,
  input  logic [63:0]       acc,
  output logic              div_start,
  output logic [MIX_W-1:0]  div_dividend,
  output logic [WSUM_W-1:0] div_divisor,
  input  logic              div_busy,
  input  logic [MIX_W-1:0]  div_quotient,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [79:0]       out_data
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_CV5  = 5'd1;
  localparam logic [4:0] ST_SPDA = 5'd2;
  localparam logic [4:0] ST_SPDB = 5'd3;
  localparam logic [4:0] ST_AMPA = 5'd4;
  localparam logic [4:0] ST_AMPB = 5'd5;
  localparam logic [4:0] ST_POS0 = 5'd6;
  localparam logic [4:0] ST_POS1 = 5'd7;
  localparam logic [4:0] ST_POS2 = 5'd8;
  localparam logic [4:0] ST_POSW = 5'd9;
  localparam logic [4:0] ST_DD   = 5'd10;
  localparam logic [4:0] ST_T2   = 5'd11;
  localparam logic [4:0] ST_T3   = 5'd12;
  localparam logic [4:0] ST_TX   = 5'd13;
  localparam logic [4:0] ST_TG   = 5'd14;
  localparam logic [4:0] ST_VA   = 5'd15;
  localparam logic [4:0] ST_VS   = 5'd16;
  localparam logic [4:0] ST_MIX  = 5'd17;
  localparam logic [4:0] ST_DIVS = 5'd18;
  localparam logic [4:0] ST_DIVW = 5'd19;

  logic [4:0] state;
  logic [4:0] state_next;

  logic [15:0]        cv_s;
  logic [15:0]        cv_a;
  logic               pres_s;
  logic               pres_a;
  logic signed [20:0] speed;
  logic signed [15:0] amp;
  logic [63:0]        pos;
  logic [OCT_W-1:0]   k;
  logic               corner;
  logic signed [39:0] nacc;
  logic signed [V_W-1:0] v [OCT_N];
  logic               neg;

  logic [8:0]   bs;
  logic [8:0]   ba;
  logic [19:0]  kspd;
  logic [14:0]  kamp;
  logic [16:0]  ucv;
  logic signed [15:0] cv5;
  logic [63:0]  pk;
  logic [15:0]  f;
  logic [7:0]   slot;
  logic [7:0]   hash;
  logic [3:0]   h;
  logic signed [4:0] g;
  logic [16:0]  d;
  logic [17:0]  x;
  logic [32:0]  omd;
  logic [16:0]  t1;
  logic [16:0]  tsq;
  logic signed [39:0] nsum;
  logic [WSUM_W-1:0] wsum;
  logic [MIX_W-1:0]  msum;
  logic [MIX_W-1:0]  mixed;
  logic              load_out;

  assign in_ready = (state == ST_IDLE);

  assign bs = (speed_blend > 9'd256) ? 9'd256 : speed_blend;
  assign ba = (amplitude_blend > 9'd256) ? 9'd256 : amplitude_blend;
  assign kspd = {base_speed, 4'b0};
  assign kamp = {base_amplitude, 3'b0};
  assign ucv = {1'b0, cv_s ^ 16'h8000} + 17'd2;
  assign cv5 = $signed({2'b00, acc[31:18]}) - 16'sd6554;

  assign pk = pos << k;
  assign f = pk[42:27];
  assign slot = pk[50:43];
  assign hash = PERM[corner ? slot + 8'd1 : slot];
  assign h = hash[3:0];
  assign g = h[3] ? -$signed({2'b00, h[2:0]} + 5'd1) : $signed({2'b00, h[2:0]} + 5'd1);
  assign d = corner ? 17'h10000 - {1'b0, f} : {1'b0, f};
  assign x = corner ? {2'b00, f} - 18'h10000 : {2'b00, f};
  assign omd = 33'h1_0000_0000 - acc[32:0];
  assign t1 = omd[32:16];
  assign tsq = acc[32:16];
  assign nsum = nacc + $signed(acc[39:0]);

  always_comb begin
    wsum = '0;
    for (int i = 0; i < OCT_N; i++) begin
      wsum = wsum + WSUM_W'(octave_weights[8*i +: 8]);
    end
  end

  assign msum = acc[MIX_W-1:0];
  assign div_start = (state == ST_DIVS);
  assign div_dividend = msum[MIX_W-1] ? ~msum : msum;
  assign div_divisor = (wsum == '0) ? WSUM_W'(1) : wsum;
  assign mixed = neg ? ~div_quotient : div_quotient;
  assign load_out = (state == ST_DIVW) && !div_busy && (!out_valid || out_ready);

  always_comb begin
    op = '0;
    unique case (state)
      ST_CV5: begin
        op.a = 40'sd52429;
        op.b = {1'b0, ucv};
      end
      ST_SPDA: begin
        op.a = {{24{cv5[15]}}, cv5};
        op.b = {9'b0, bs};
      end
      ST_SPDB: begin
        op.add = 1'b1;
        op.a = {20'b0, kspd};
        op.b = {9'b0, 9'd256 - bs};
      end
      ST_AMPA: begin
        op.a = {{24{cv_a[15]}}, cv_a};
        op.b = {9'b0, ba};
      end
      ST_AMPB: begin
        op.add = 1'b1;
        op.a = {25'b0, kamp};
        op.b = {9'b0, 9'd256 - ba};
      end
      ST_POS0: begin
        op.a = {{19{speed[20]}}, speed};
        op.b = {2'b00, elapsed_time[15:0]};
      end
      ST_POS1: begin
        op.add = 1'b1;
        op.sh = SH_16;
        op.a = {{19{speed[20]}}, speed};
        op.b = {2'b00, elapsed_time[31:16]};
      end
      ST_POS2: begin
        op.add = 1'b1;
        op.sh = SH_32;
        op.a = {{19{speed[20]}}, speed};
        op.b = {2'b00, elapsed_time[47:32]};
      end
      ST_DD: begin
        op.a = {23'b0, d};
        op.b = {1'b0, d};
      end
      ST_T2: begin
        op.a = {23'b0, t1};
        op.b = {1'b0, t1};
      end
      ST_T3: begin
        op.a = {23'b0, tsq};
        op.b = {1'b0, tsq};
      end
      ST_TX: begin
        op.a = {23'b0, tsq};
        op.b = x;
      end
      ST_TG: begin
        op.a = acc[39:0];
        op.b = {{13{g[4]}}, g};
      end
      ST_VA: begin
        op.a = nsum;
        op.b = {{2{amp[15]}}, amp};
      end
      ST_MIX: begin
        op.add = (k != '0);
        op.a = {{(40-V_W){v[k][V_W-1]}}, v[k]};
        op.b = {10'b0, octave_weights[8*k +: 8]};
      end
      default: op = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_CV5;
      ST_CV5:  state_next = ST_SPDA;
      ST_SPDA: state_next = ST_SPDB;
      ST_SPDB: state_next = ST_AMPA;
      ST_AMPA: state_next = ST_AMPB;
      ST_AMPB: state_next = ST_POS0;
      ST_POS0: state_next = ST_POS1;
      ST_POS1: state_next = ST_POS2;
      ST_POS2: state_next = ST_POSW;
      ST_POSW: state_next = ST_DD;
      ST_DD:   state_next = ST_T2;
      ST_T2:   state_next = ST_T3;
      ST_T3:   state_next = ST_TX;
      ST_TX:   state_next = ST_TG;
      ST_TG:   state_next = corner ? ST_VA : ST_DD;
      ST_VA:   state_next = ST_VS;
      ST_VS:   state_next = (k == OCT_W'(OCT_N - 1)) ? ST_MIX : ST_DD;
      ST_MIX:  state_next = (k == OCT_W'(OCT_N - 1)) ? ST_DIVS : ST_MIX;
      ST_DIVS: state_next = ST_DIVW;
      ST_DIVW: if (load_out) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      k <= '0;
      corner <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_TG) begin
        corner <= !corner;
      end
      if (state == ST_VS || state == ST_MIX) begin
        k <= (k == OCT_W'(OCT_N - 1)) ? '0 : k + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      cv_s <= speed_cv;
      cv_a <= amp_cv;
      pres_s <= speed_cv_present;
      pres_a <= amp_cv_present;
    end
    if (state == ST_AMPA) begin
      speed <= pres_s ? $signed(acc[28:8]) : $signed({1'b0, kspd});
    end
    if (state == ST_POS0) begin
      amp <= pres_a ? $signed(acc[23:8]) : $signed({1'b0, kamp});
    end
    if (state == ST_POSW) begin
      pos <= acc;
    end
    if (state == ST_DD && corner) begin
      nacc <= $signed(acc[39:0]);
    end
    if (state == ST_VS) begin
      v[k] <= $signed(acc[V_W+33:34]);
    end
    if (state == ST_DIVS) begin
      neg <= msum[MIX_W-1];
    end
    if (load_out) begin
      out_data[15:0] <= sat16(mixed);
      for (int i = 0; i < OCT_N; i++) begin
        out_data[16*(i+1) +: 16] <= sat16({{(MIX_W-V_W){v[i][V_W-1]}}, v[i]});
      end
    end
  end

endmodule

// ===== design/octave_simplex_noise_generator_unit.sv =====
// Four-octave 1D simplex noise source, one item per sample tick. Each accepted
// item advances the Q16.32 time by time_step, forms speed and amplitude from
// the knobs and any present control voltages, evaluates the octaves at 1x, 2x,
// 4x and 8x speed and returns one result item with the saturated octaves and
// their weighted mean. The result is built from 56 products on the single
// shared 40x18 multiplier, one per cycle, with the POSW and VS sequencing
// states between them, then a start state, 28 bit-serial divider steps and a
// load state for the weighted mean. s_tready is low until the result is loaded,
// so no new item is taken before the last is done. A finished result waits in the
// output register; a following item stalls before its own load until it is taken.
module octave_simplex_noise_generator_unit
  import osng_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // speed_cv [15:0], amp_cv [31:16]
  input  logic [1:0]  s_tuser,  // speed_cv_present [0], amp_cv_present [1]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,  // mixed_noise, octave0_noise .. octave3_noise, 16 bits each
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [2:0] REG_TIME_STEP = 3'd0;
  localparam logic [2:0] REG_BASE_SPEED = 3'd1;
  localparam logic [2:0] REG_SPEED_BLEND = 3'd2;
  localparam logic [2:0] REG_BASE_AMP = 3'd3;
  localparam logic [2:0] REG_AMP_BLEND = 3'd4;
  localparam logic [2:0] REG_WEIGHTS = 3'd5;

  logic [31:0] time_step;
  logic [15:0] base_speed;
  logic [8:0]  speed_blend;
  logic [11:0] base_amplitude;
  logic [8:0]  amplitude_blend;
  logic [31:0] octave_weights;
  logic [47:0] elapsed_time;

  mac_op_t           op;
  logic [63:0]       acc;
  logic              div_start;
  logic [MIX_W-1:0]  div_dividend;
  logic [WSUM_W-1:0] div_divisor;
  logic              div_busy;
  logic [MIX_W-1:0]  div_quotient;
  logic              accept;

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= 32'd89478;
      base_speed <= 16'd32064;
      speed_blend <= 9'd128;
      base_amplitude <= 12'd256;
      amplitude_blend <= 9'd128;
      octave_weights <= 32'd1077952576;
      elapsed_time <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TIME_STEP:   time_step <= cfg_data;
          REG_BASE_SPEED:  base_speed <= cfg_data[15:0];
          REG_SPEED_BLEND: speed_blend <= cfg_data[8:0];
          REG_BASE_AMP:    base_amplitude <= cfg_data[11:0];
          REG_AMP_BLEND:   amplitude_blend <= cfg_data[8:0];
          REG_WEIGHTS:     octave_weights <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        elapsed_time <= elapsed_time + {16'b0, time_step};
      end
    end
  end

  osng_mac u_mac (
    .clk (clk),
    .op  (op),
    .acc (acc)
  );

  osng_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  osng_seq u_seq (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (s_tvalid),
    .in_ready         (s_tready),
    .speed_cv         (s_tdata[15:0]),
    .speed_cv_present (s_tuser[0]),
    .amp_cv           (s_tdata[31:16]),
    .amp_cv_present   (s_tuser[1]),
    .elapsed_time     (elapsed_time),
    .base_speed       (base_speed),
    .speed_blend      (speed_blend),
    .base_amplitude   (base_amplitude),
    .amplitude_blend  (amplitude_blend),
    .octave_weights   (octave_weights),
    .op               (op),
    .acc              (acc),
    .div_start        (div_start),
    .div_dividend     (div_dividend),
    .div_divisor      (div_divisor),
    .div_busy         (div_busy),
    .div_quotient     (div_quotient),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .out_data         (m_tdata)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("input accepted while an item is in progress");

  a_time_advance: assert property (@(posedge clk) disable iff (rst)
    accept |=> elapsed_time == $past(elapsed_time) + {16'b0, $past(time_step)})
    else $error("time did not advance by one step");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !div_busy)
    else $error("divider busy while idle");
`endif

endmodule
